// ===== hdl/stbs_pkg.sv =====
// Shared types and constants for the sorted table binary search block.
package stbs_pkg;

  localparam int KEY_W      = 17;
  localparam int PORT_W     = 16;
  localparam int INDEX_W    = 10;
  localparam int NAME_W     = 64;
  localparam int COUNT_W    = 11;
  localparam int IN_TDATA_W = 96;
  localparam int OUT_TDATA_W = 64;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_DONE
  } state_e;

endpackage

// ===== hdl/sorted_table_binary_search.sv =====
// Top level of the sorted port/service table with binary-search lookup.
// The block holds up to MAX_ENTRIES records, each a 17-bit key (port * 2 + udp)
// and a name of NAME_BYTES bytes. An input transfer with tuser = 0 writes one
// record at entry_index (indexes at or above MAX_ENTRIES are dropped); with
// tuser = 1 it looks up port/udp over the first entry_count records, which must
// have been written in ascending key order. Every input transfer yields exactly
// one output transfer: tuser = found, tdata = the name cut at its first zero
// byte, or zero on a miss and for writes. The user must load entry_count over
// the cfg channel only while the block is idle; the block does not enforce it.
// Values above MAX_ENTRIES act as MAX_ENTRIES. One item is in flight at a time
// and s_axis_tready is low while it works. A write goes straight to the done
// state. A lookup repeats a probe step (the table memory read at the midpoint)
// and a compare step (the key compare); it ends on a match, or on a miss when
// one more probe step sees the empty range.
// A finished result waits in the output register; the next item is accepted
// as soon as that result has been handed over or parked there.
module sorted_table_binary_search #(
  parameter int MAX_ENTRIES = 1024,
  parameter int NAME_BYTES  = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // cfg write channel: entry_count
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [stbs_pkg::COUNT_W-1:0]      cfg_data_i,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata, from bit 0: entry_index[9:0], port[25:10], udp[26],
  // service_name[90:27], zero fill[95:91]
  input  logic [stbs_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // tuser: op (0 write, 1 lookup)
  input  logic                              s_axis_tuser,
  // output stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: matched_name[63:0]
  output logic [stbs_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // tuser: found
  output logic                              m_axis_tuser
);
  import stbs_pkg::*;

  localparam int AW  = $clog2(MAX_ENTRIES);
  localparam int NW  = $clog2(MAX_ENTRIES + 1);
  localparam int NBW = 8 * NAME_BYTES;

  // Unpack the input stream.
  logic [INDEX_W-1:0] in_index;
  logic [PORT_W-1:0]  in_port;
  logic               in_udp;
  logic [NAME_W-1:0]  in_name;
  logic [KEY_W-1:0]   in_key;

  assign in_index = s_axis_tdata[9:0];
  assign in_port  = s_axis_tdata[25:10];
  assign in_udp   = s_axis_tdata[26];
  assign in_name  = s_axis_tdata[90:27];
  assign in_key   = {in_port, in_udp};

  logic in_fire, out_fire, cfg_fire;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign cfg_fire = cfg_valid_i && cfg_ready_o;

  // Registers.
  state_e             state_q, state_d;
  logic [COUNT_W-1:0] cnt_q;
  logic [NW-1:0]      lo_q, lo_d;     // lowest candidate position
  logic [NW-1:0]      hx_q, hx_d;     // one past the highest candidate position
  logic [NW-1:0]      mid_q, mid_d;   // position being probed
  logic [KEY_W-1:0]   target_q, target_d;
  logic               res_found_q, res_found_d;
  logic [NAME_W-1:0]  res_name_q, res_name_d;
  logic               out_valid_q, out_valid_d;
  logic               out_found_q, out_found_d;
  logic [NAME_W-1:0]  out_name_q, out_name_d;

  // Table.
  logic               wr_en, rd_en, idx_ok;
  logic [KEY_W-1:0]   rd_key;
  logic [NBW-1:0]     rd_name;
  logic [NW:0]        mid_sum;

  assign idx_ok = 32'(in_index) < 32'(MAX_ENTRIES);

  // Read at the new midpoint so its key is ready for the compare cycle.
  stbs_table #(
    .Depth    (MAX_ENTRIES),
    .NameBits (NBW)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (AW'(32'(in_index))),
    .wr_key_i  (in_key),
    .wr_name_i (in_name[NBW-1:0]),
    .rd_en_i   (rd_en),
    .rd_addr_i (mid_sum[AW-1:0]),
    .rd_key_o  (rd_key),
    .rd_name_o (rd_name)
  );

  // Cut the stored name at its first zero byte.
  logic [NAME_W-1:0] shaped_name;
  always_comb begin
    logic seen_zero;
    seen_zero   = 1'b0;
    shaped_name = '0;
    for (int i = 0; i < NAME_BYTES; i++) begin
      if (rd_name[8*i +: 8] == 8'd0) begin
        seen_zero = 1'b1;
      end
      if (!seen_zero) begin
        shaped_name[8*i +: 8] = rd_name[8*i +: 8];
      end
    end
  end

  logic          range_empty;
  logic          out_free;

  assign range_empty = lo_q >= hx_q;
  assign mid_sum     = ({1'b0, lo_q} + {1'b0, hx_q} - (NW+1)'(1)) >> 1;
  assign out_free    = !out_valid_q || m_axis_tready;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = (s_axis_tuser == OP_LOOKUP) ? ST_PROBE : ST_DONE;
        end
      end
      ST_PROBE: begin
        state_d = range_empty ? ST_DONE : ST_CMP;
      end
      ST_CMP: begin
        state_d = (rd_key == target_q) ? ST_DONE : ST_PROBE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs and datapath updates.
  always_comb begin
    s_axis_tready = 1'b0;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    lo_d          = lo_q;
    hx_d          = hx_q;
    mid_d         = mid_q;
    target_d      = target_q;
    res_found_d   = res_found_q;
    res_name_d    = res_name_q;
    out_valid_d   = out_valid_q && !out_fire;
    out_found_d   = out_found_q;
    out_name_d    = out_name_q;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        wr_en         = in_fire && (s_axis_tuser == OP_WRITE) && idx_ok;
        // Start a lookup over [0, min(entry_count, MAX_ENTRIES)).
        target_d    = in_key;
        lo_d        = '0;
        hx_d        = (32'(cnt_q) > 32'(MAX_ENTRIES)) ? NW'(MAX_ENTRIES) : NW'(cnt_q);
        res_found_d = 1'b0;
        res_name_d  = '0;
      end
      ST_PROBE: begin
        rd_en = !range_empty;
        mid_d = mid_sum[NW-1:0];
      end
      ST_CMP: begin
        if (rd_key == target_q) begin
          res_found_d = 1'b1;
          res_name_d  = shaped_name;
        end else if (rd_key < target_q) begin
          lo_d = mid_q + NW'(1);
        end else begin
          hx_d = mid_q;
        end
      end
      ST_DONE: begin
        // Park the result in the output register once it is free.
        if (out_free) begin
          out_valid_d = 1'b1;
          out_found_d = res_found_q;
          out_name_d  = res_name_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_fire) begin
        cnt_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q        <= lo_d;
    hx_q        <= hx_d;
    mid_q       <= mid_d;
    target_q    <= target_d;
    res_found_q <= res_found_d;
    res_name_q  <= res_name_d;
    out_found_q <= out_found_d;
    out_name_q  <= out_name_d;
  end

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_found_q;
  assign m_axis_tdata  = out_name_q;

endmodule

// ===== hdl/stbs_table.sv =====
// Record table: key and name memories, one write port and one registered read port.
module stbs_table #(
  parameter int Depth    = 1024,
  parameter int NameBits = 64,
  localparam int AW      = $clog2(Depth)
) (
  input  logic                        clk_i,
  input  logic                        wr_en_i,
  input  logic [AW-1:0]               wr_addr_i,
  input  logic [stbs_pkg::KEY_W-1:0]  wr_key_i,
  input  logic [NameBits-1:0]         wr_name_i,
  input  logic                        rd_en_i,
  input  logic [AW-1:0]               rd_addr_i,
  output logic [stbs_pkg::KEY_W-1:0]  rd_key_o,
  output logic [NameBits-1:0]         rd_name_o
);
  import stbs_pkg::*;

  logic [KEY_W-1:0]    key_mem [Depth];
  logic [NameBits-1:0] name_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      key_mem[wr_addr_i]  <= wr_key_i;
      name_mem[wr_addr_i] <= wr_name_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_key_o  <= key_mem[rd_addr_i];
      rd_name_o <= name_mem[rd_addr_i];
    end
  end

endmodule

// ===== hdl/stbs_checker.sv =====
// Port-level checks for the sorted table binary search block, with its bind.
module stbs_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [stbs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                             m_axis_tuser
);
  import stbs_pkg::*;

  // One item at a time: drop ready right after an input transfer.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an item is still in work");

  // A miss or a write always carries a zero name.
  a_miss_zero_name: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("result without match carries a nonzero name");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed or vanished");

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
